### hw/rtl/lru_page_replacement_top_defines.svh
// ---------------------------------------------------------------------------
// LRU page replacement - assertion macros
// Shared property forms for the checker.
// ---------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LRUPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LRUPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lrupr_pkg.sv
// ---------------------------------------------------------------------------
// LRU page replacement - package
// Word types and the structs passed along the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    // bounds of the build parameters: up to 64 frames, up to 32 page bits
    localparam int C_IDX_W  = 6;
    localparam int C_PAGE_W = 32;

    typedef struct packed {
        logic [15:0] page;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [2:0]  frame_slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [31:0] hit_count;
        logic [31:0] fault_count;
    } t_res;

    typedef struct packed {
        logic [3:0] num_frames;
    } t_cfg;

    typedef struct packed {
        logic                hit;
        logic [C_IDX_W-1:0]  hit_slot;
        logic [C_IDX_W-1:0]  hit_rank;
        logic [C_IDX_W-1:0]  lru_slot;
        logic [C_PAGE_W-1:0] lru_page;
    } t_scan;

    typedef struct packed {
        logic               commit;
        logic               hit;
        logic [C_IDX_W-1:0] slot;
        logic [C_IDX_W-1:0] old_rank;
        logic [C_IDX_W:0]   filled;
    } t_upd;

endpackage

`default_nettype wire

### hw/rtl/lrupr_stream_if.sv
// ---------------------------------------------------------------------------
// LRU page replacement - stream interface
// Valid/ready channel carrying one word of type T.
// ---------------------------------------------------------------------------
`default_nettype none

interface lrupr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/lrupr_cell.sv
// ---------------------------------------------------------------------------
// LRU page replacement - frame cell
// Holds one frame's page and recency rank, folds its match and LRU candidate into the scan word.
// ---------------------------------------------------------------------------
`default_nettype none

module lrupr_cell #(
    parameter int CELL_IDX = 0,
    parameter int RANK_W   = 3,
    parameter int PAGE_W   = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [PAGE_W-1:0] i_key,
    input  wire lrupr_pkg::t_scan  i_acc,
    output lrupr_pkg::t_scan       o_acc,
    input  wire lrupr_pkg::t_upd   i_upd,
    input  wire logic              i_clear
);
    import lrupr_pkg::*;

    logic [PAGE_W-1:0]  r_page;
    logic [RANK_W-1:0]  r_rank;
    logic [RANK_W-1:0]  n_rank;
    t_scan              r_acc;
    t_scan              n_acc;
    logic               w_valid;
    logic               w_me;
    logic [C_IDX_W-1:0] w_last;

    assign w_valid = (C_IDX_W + 1)'(CELL_IDX) < i_upd.filled;
    assign w_me    = i_upd.slot == C_IDX_W'(CELL_IDX);
    assign w_last  = C_IDX_W'(i_upd.filled - 1'b1);

    always_comb begin
        n_acc = i_acc;
        if (w_valid && !i_acc.hit && r_page == i_key) begin
            n_acc.hit      = 1'b1;
            n_acc.hit_slot = C_IDX_W'(CELL_IDX);
            n_acc.hit_rank = C_IDX_W'(r_rank);
        end
        if (w_valid && C_IDX_W'(r_rank) == w_last) begin
            n_acc.lru_slot = C_IDX_W'(CELL_IDX);
            n_acc.lru_page = C_PAGE_W'(r_page);
        end
    end

    always_comb begin
        n_rank = r_rank;
        if (w_me) begin
            n_rank = '0;
        end else if (w_valid) begin
            if (!i_upd.hit || C_IDX_W'(r_rank) < i_upd.old_rank) begin
                n_rank = r_rank + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_upd.commit && !i_upd.hit && w_me) begin
            r_page <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= '0;
        end else if (i_clear) begin
            r_rank <= '0;
        end else if (i_upd.commit) begin
            r_rank <= n_rank;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### hw/rtl/lru_page_replacement_top.sv
// ---------------------------------------------------------------------------
// LRU page replacement - top level
// Resident page table with recency ranks, built as a row of frame cells.
// ---------------------------------------------------------------------------
// Usage:
//   i_req carries one page reference per word; o_res returns one result word
//   per reference (hit, frame, evicted page, hit and fault counts).
//   i_cfg writes num_frames, clearing the table and both counters; the user must
//   write only while idle, unenforced by the block; i_cfg.ready is always high.
// Timing:
//   The reference is broadcast to the cell row while a scan word travels one
//   cell per cycle through the cells' registers, in the scan state. The
//   commit state then commits the update and loads the result register. A
//   new reference is taken only after the previous one has committed and the
//   block is back in idle.
// Reset:
//   Synchronous, active low: table empty, counters zero, num_frames = 3
//   (capped at MAX_FRAMES), no result pending.
// Stall:
//   The result register holds while o_res.ready is low. A new reference is
//   still taken; its commit waits until the held result has gone.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    lrupr_stream_if.sink   i_req,
    lrupr_stream_if.source o_res,
    lrupr_stream_if.sink   i_cfg
);
    import lrupr_pkg::*;

    localparam int FILL_W    = $clog2(MAX_FRAMES + 1);
    localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RESET_NUM = (3 > MAX_FRAMES) ? MAX_FRAMES : 3;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]           r_state;
    logic [IDX_W-1:0]     r_cnt;
    logic [PAGE_BITS-1:0] r_key;
    logic [FILL_W-1:0]    r_filled;
    logic [FILL_W-1:0]    r_num;
    logic [FILL_W-1:0]    n_num;
    logic [31:0]          r_hits;
    logic [31:0]          r_faults;
    logic [31:0]          n_hits;
    logic [31:0]          n_faults;
    logic                 r_out_valid;
    t_res                 r_out;
    t_res                 n_out;
    t_scan                w_acc [MAX_FRAMES+1];
    t_scan                w_res;
    t_upd                 w_upd;
    logic                 w_req_acc;
    logic                 w_cfg_acc;
    logic                 w_commit;
    logic                 w_fill;
    logic [C_IDX_W-1:0]   w_slot;

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign i_req.ready = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign w_commit    = (r_state == S_COMMIT) && (!r_out_valid || o_res.ready);

    assign w_acc[0] = '0;
    assign w_res    = w_acc[MAX_FRAMES];

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lrupr_cell #(
            .CELL_IDX (g),
            .RANK_W   (IDX_W),
            .PAGE_W   (PAGE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_acc   (w_acc[g]),
            .o_acc   (w_acc[g+1]),
            .i_upd   (w_upd),
            .i_clear (w_cfg_acc)
        );
    end

    assign w_fill = r_filled < r_num;

    always_comb begin
        if (w_res.hit) begin
            w_slot = w_res.hit_slot;
        end else if (w_fill) begin
            w_slot = C_IDX_W'(r_filled);
        end else begin
            w_slot = w_res.lru_slot;
        end
    end

    always_comb begin
        w_upd.commit   = w_commit;
        w_upd.hit      = w_res.hit;
        w_upd.slot     = w_slot;
        w_upd.old_rank = w_res.hit_rank;
        w_upd.filled   = (C_IDX_W + 1)'(r_filled);
    end

    always_comb begin
        n_hits   = r_hits;
        n_faults = r_faults;
        if (w_res.hit) begin
            if (r_hits != '1) begin
                n_hits = r_hits + 32'd1;
            end
        end else begin
            if (r_faults != '1) begin
                n_faults = r_faults + 32'd1;
            end
        end
        n_out.hit           = w_res.hit;
        n_out.frame_slot    = 3'(w_slot);
        n_out.evicted_valid = !w_res.hit && !w_fill;
        n_out.evicted_page  = (!w_res.hit && !w_fill) ? 16'(w_res.lru_page) : 16'd0;
        n_out.hit_count     = n_hits;
        n_out.fault_count   = n_faults;
    end

    always_comb begin
        if (i_cfg.data.num_frames == 4'd0) begin
            n_num = FILL_W'(1);
        end else if (32'(i_cfg.data.num_frames) > MAX_FRAMES) begin
            n_num = FILL_W'(MAX_FRAMES);
        end else begin
            n_num = FILL_W'(i_cfg.data.num_frames);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_key <= PAGE_BITS'(i_req.data.page);
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_filled    <= '0;
            r_num       <= FILL_W'(RESET_NUM);
            r_hits      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                r_num    <= n_num;
                r_filled <= '0;
                r_hits   <= '0;
                r_faults <= '0;
            end else if (w_commit) begin
                r_hits   <= n_hits;
                r_faults <= n_faults;
                if (!w_res.hit && w_fill) begin
                    r_filled <= r_filled + FILL_W'(1);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == IDX_W'(MAX_FRAMES - 1)) begin
                        r_state <= S_COMMIT;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_COMMIT: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

### hw/rtl/lrupr_checker.sv
// ---------------------------------------------------------------------------
// LRU page replacement - port checker
// Watches the top level's channels and flags inconsistent results.
// ---------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_top_defines.svh"

module lrupr_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_req_valid,
    input wire logic            i_req_ready,
    input wire logic            o_res_valid,
    input wire logic            o_res_ready,
    input wire lrupr_pkg::t_res o_res_data
);
    import lrupr_pkg::*;

    `LRUPR_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !o_res_ready,
        o_res_valid && $stable(o_res_data), "result word changed while stalled")

    `LRUPR_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && i_req_ready,
        !i_req_ready, "second reference taken while one is in flight")

    `LRUPR_ASSERT_IMP(a_evict_page, i_clk, i_rst_n, o_res_valid && !o_res_data.evicted_valid,
        o_res_data.evicted_page == 16'd0, "evicted page set without an eviction")

    `LRUPR_ASSERT_IMP(a_hit_clean, i_clk, i_rst_n, o_res_valid && o_res_data.hit,
        !o_res_data.evicted_valid && o_res_data.hit_count != 32'd0,
        "hit result reports an eviction or a zero hit count")

endmodule

bind lru_page_replacement_top lrupr_checker u_lrupr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .o_res_valid (o_res.valid),
    .o_res_ready (o_res.ready),
    .o_res_data  (o_res.data)
);

`default_nettype wire

### dv/lru_page_replacement_top_tb.sv
// ---------------------------------------------------------------------------
// LRU page replacement - testbench
// Sends page references and frame-count writes, with random gaps on the
// request side and random stalls on the result side. A recency-rank model
// of the page table predicts each result word, and every field is compared
// in order. A short table of directed references and writes comes first,
// then random phases that mostly reuse a small working set of pages.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top_tb;
    import lrupr_pkg::*;

    localparam int MAX_FRAMES  = 8;
    localparam int PAGE_BITS   = 16;
    localparam int SETTLE      = MAX_FRAMES + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_REFS  = 150;
    localparam int DIR_ROWS    = 25;

    typedef enum logic {ROW_REF, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [15:0] value;
        logic        typed;
        logic        hit;
        logic [2:0]  slot;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] hits;
        logic [31:0] faults;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    lrupr_stream_if #(.T(t_req)) req_if ();
    lrupr_stream_if #(.T(t_res)) res_if ();
    lrupr_stream_if #(.T(t_cfg)) cfg_if ();

    lru_page_replacement_top #(
        .MAX_FRAMES(MAX_FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_res  (res_if.source),
        .i_cfg  (cfg_if.sink)
    );

    logic [15:0] frame_pages [MAX_FRAMES];
    int          frame_ranks [MAX_FRAMES];
    int          frames_filled;
    int          frames_in_use;
    logic [31:0] hits_seen;
    logic [31:0] faults_seen;

    t_res        pending_results [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          steady;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_REF, 16'h0000, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1},
        '{ROW_REF, 16'hFFFF, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd0, 32'd2},
        '{ROW_REF, 16'h0000, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd2},
        '{ROW_REF, 16'h5555, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd1, 32'd3},
        '{ROW_REF, 16'hAAAA, 1'b1, 1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd1, 32'd4},
        '{ROW_REF, 16'h0000, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_REF, 16'hFFFF, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_CFG, 16'h0000, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_REF, 16'h1234, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1},
        '{ROW_REF, 16'h1234, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000, 32'd1, 32'd1},
        '{ROW_REF, 16'h4321, 1'b1, 1'b0, 3'd0, 1'b1, 16'h1234, 32'd1, 32'd2},
        '{ROW_CFG, 16'h000F, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_REF, 16'h0001, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1},
        '{ROW_REF, 16'h0002, 1'b1, 1'b0, 3'd1, 1'b0, 16'h0000, 32'd0, 32'd2},
        '{ROW_REF, 16'h0004, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000, 32'd0, 32'd3},
        '{ROW_REF, 16'h0008, 1'b1, 1'b0, 3'd3, 1'b0, 16'h0000, 32'd0, 32'd4},
        '{ROW_REF, 16'h0010, 1'b1, 1'b0, 3'd4, 1'b0, 16'h0000, 32'd0, 32'd5},
        '{ROW_REF, 16'h0020, 1'b1, 1'b0, 3'd5, 1'b0, 16'h0000, 32'd0, 32'd6},
        '{ROW_REF, 16'h0040, 1'b1, 1'b0, 3'd6, 1'b0, 16'h0000, 32'd0, 32'd7},
        '{ROW_REF, 16'h0080, 1'b1, 1'b0, 3'd7, 1'b0, 16'h0000, 32'd0, 32'd8},
        '{ROW_REF, 16'h0001, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_REF, 16'h8000, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_CFG, 16'h0008, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0},
        '{ROW_REF, 16'hFFFF, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd1},
        '{ROW_CFG, 16'h0003, 1'b0, 1'b0, 3'd0, 1'b0, 16'h0000, 32'd0, 32'd0}
    };

    function automatic void clear_table();
        for (int i = 0; i < MAX_FRAMES; i++) begin
            frame_pages[i] = '0;
            frame_ranks[i] = 0;
        end
        frames_filled = 0;
        hits_seen     = '0;
        faults_seen   = '0;
    endfunction

    function automatic void set_frame_count(input logic [3:0] value);
        if (value == 4'd0) begin
            frames_in_use = 1;
        end else if (int'(value) > MAX_FRAMES) begin
            frames_in_use = MAX_FRAMES;
        end else begin
            frames_in_use = int'(value);
        end
        clear_table();
    endfunction

    function automatic t_res lru_reference(input logic [15:0] pg);
        t_res r;
        int   slot;
        int   prior;
        bit   found;
        r     = '0;
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < frames_filled; i++) begin
            if (!found && frame_pages[i] == pg) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            prior = frame_ranks[slot];
            for (int i = 0; i < frames_filled; i++) begin
                if (frame_ranks[i] < prior) frame_ranks[i]++;
            end
            frame_ranks[slot] = 0;
            if (hits_seen != '1) hits_seen++;
        end else begin
            if (frames_filled < frames_in_use) begin
                slot = frames_filled;
                for (int i = 0; i < frames_filled; i++) frame_ranks[i]++;
                frames_filled++;
            end else begin
                for (int i = 0; i < frames_filled; i++) begin
                    if (frame_ranks[i] == frames_filled - 1) slot = i;
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_pages[slot];
                for (int i = 0; i < frames_filled; i++) begin
                    if (i != slot) frame_ranks[i]++;
                end
            end
            frame_pages[slot] = pg;
            frame_ranks[slot] = 0;
            if (faults_seen != '1) faults_seen++;
        end
        r.hit         = found;
        r.frame_slot  = 3'(slot);
        r.hit_count   = hits_seen;
        r.fault_count = faults_seen;
        return r;
    endfunction

    // drop valid for random gaps, then hold it until the reference is taken
    task automatic send_page(input logic [15:0] pg, output t_res predicted);
        while (!steady && $urandom_range(0, 99) < 14) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.data.page <= pg;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = lru_reference(pg);
    endtask

    task automatic write_frame_count(input logic [3:0] value);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        cfg_if.valid           <= 1'b1;
        cfg_if.data.num_frames <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        set_frame_count(value);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // compare each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.frame_slot !== want.frame_slot ||
                    got.evicted_valid !== want.evicted_valid ||
                    got.evicted_page !== want.evicted_page ||
                    got.hit_count !== want.hit_count ||
                    got.fault_count !== want.fault_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
        res_if.ready <= steady || ($urandom_range(0, 99) >= 14);
    end

    initial begin
        t_res        predicted;
        logic [15:0] pool [MAX_FRAMES + 4];
        logic [15:0] pg;
        int          pool_size;
        int          roll;
        int          sent;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        steady       = 1'b0;
        sent         = 0;
        set_frame_count(4'd3);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CFG) begin
                write_frame_count(dir_rows[n].value[3:0]);
            end else begin
                send_page(dir_rows[n].value, predicted);
                if (dir_rows[n].typed) begin
                    predicted.hit           = dir_rows[n].hit;
                    predicted.frame_slot    = dir_rows[n].slot;
                    predicted.evicted_valid = dir_rows[n].ev_valid;
                    predicted.evicted_page  = dir_rows[n].ev_page;
                    predicted.hit_count     = dir_rows[n].hits;
                    predicted.fault_count   = dir_rows[n].faults;
                end
                pending_results.push_back(predicted);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            write_frame_count(4'($urandom_range(0, 15)));
            pool_size = frames_in_use + $urandom_range(0, 3);
            for (int k = 0; k < pool_size; k++) pool[k] = 16'($urandom);
            for (int k = 0; k < PHASE_REFS; k++) begin
                steady = (sent >= 700 && sent < 1000);
                roll   = $urandom_range(0, 99);
                pg     = pool[$urandom_range(0, pool_size - 1)];
                if (roll < 8) begin
                    pg = 16'($urandom);
                end else if (roll < 16) begin
                    pg[$urandom_range(0, 15)] = ~pg[$urandom_range(0, 15)];
                end else if (roll < 19) begin
                    pool[$urandom_range(0, pool_size - 1)] = 16'($urandom);
                end
                send_page(pg, predicted);
                pending_results.push_back(predicted);
                sent++;
            end
        end
        steady = 1'b0;

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
